@@ hw/rtl/dcts_pkg.sv @@
`default_nettype none

package dcts_pkg;

   localparam int unsigned LEN_BITS   = 7;
   localparam int unsigned ADDR_BITS  = 6;
   localparam int unsigned INDEX_BITS = 4;
   localparam int unsigned COUNT_BITS = 5;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   localparam logic [7:0] COLON_BYTE = 8'h3a;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   localparam logic KIND_TX_BYTE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_TOO_LONG = 1'b1;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_TOKEN   = 2'd1;
   localparam logic [1:0] OP_SUMMARY = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [15:0] message_length;
      logic [7:0]  data;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [7:0]            out_byte;
      logic [INDEX_BITS-1:0] tx_index;
      logic                  tx_last;
      logic                  status;
      logic [COUNT_BITS-1:0] tx_count;
      logic                  run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]            opcode;
      logic [ADDR_BITS-1:0]  addr;
      logic [7:0]            value;
      logic [LEN_BITS-1:0]   length;
      logic [INDEX_BITS-1:0] index;
      logic                  status;
      logic [COUNT_BITS-1:0] count;
      logic                  run_last;
   } op_type;

endpackage

`default_nettype wire

@@ hw/rtl/dcts_front.sv @@
`default_nettype none

module dcts_front #(
   parameter int unsigned TX_BYTES_MAX = 32,
   parameter int unsigned TXS_MAX      = 16,
   parameter int unsigned PAYLOAD_MAX  = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire dcts_pkg::req_type req_word,
   output logic                  op_push,
   input  wire logic             op_full,
   output dcts_pkg::op_type      op_word
);

   localparam int unsigned LEN_W  = $clog2(TX_BYTES_MAX + 2);
   localparam int unsigned CNT_W  = $clog2(TXS_MAX + 1);
   localparam int unsigned OPS_MAX = 4;

   localparam logic [LEN_W-1:0] TXB_L   = LEN_W'(TX_BYTES_MAX);
   localparam logic [LEN_W-1:0] TXB1_L  = LEN_W'(TX_BYTES_MAX + 1);
   localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);
   localparam logic [CNT_W-1:0] TXS_L   = CNT_W'(TXS_MAX);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
   localparam logic [15:0]      PMAX_L  = 16'(PAYLOAD_MAX);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_PARSE  = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;
   localparam logic [1:0] PH_IGNORE = 2'd3;

   function automatic dcts_pkg::op_type mk_write(logic [LEN_W-1:0] addr, logic [7:0] value);
      dcts_pkg::op_type o;
      o          = '0;
      o.opcode   = dcts_pkg::OP_WRITE;
      o.addr     = dcts_pkg::ADDR_BITS'(addr);
      o.value    = value;
      return o;
   endfunction

   function automatic dcts_pkg::op_type mk_token(logic [LEN_W-1:0] len, logic [CNT_W-1:0] idx,
                                                 logic rl);
      dcts_pkg::op_type o;
      o          = '0;
      o.opcode   = dcts_pkg::OP_TOKEN;
      o.length   = dcts_pkg::LEN_BITS'(len);
      o.index    = dcts_pkg::INDEX_BITS'(idx);
      o.run_last = rl;
      return o;
   endfunction

   function automatic dcts_pkg::op_type mk_summary(logic st, logic [CNT_W-1:0] cnt);
      dcts_pkg::op_type o;
      o          = '0;
      o.opcode   = dcts_pkg::OP_SUMMARY;
      o.status   = st;
      o.count    = dcts_pkg::COUNT_BITS'(cnt);
      o.run_last = 1'b1;
      return o;
   endfunction

   logic [LEN_W-1:0] tl_ff, tl_in;
   logic             ch_ff, ch_in;
   logic [CNT_W-1:0] ac_ff, ac_in;
   logic [1:0]       ph_ff, ph_in;

   dcts_pkg::op_type ops_ff [OPS_MAX];
   dcts_pkg::op_type ops_in [OPS_MAX];
   logic [2:0]       nops_ff, nops_in;
   logic [2:0]       pos_ff, pos_in;

   logic pending;
   logic accept;

   assign pending  = (pos_ff != nops_ff);
   assign req_full = pending;
   assign accept   = req_push && !req_full;
   assign op_push  = pending && !op_full;
   assign op_word  = ops_ff[pos_ff[1:0]];

   always_comb begin
      logic [LEN_W-1:0] l;
      logic             ch;
      logic [CNT_W-1:0] ac;
      logic [1:0]       ph;
      logic [2:0]       n;
      logic             is_zero;
      logic             is_colon;
      logic             pair;
      l        = tl_ff;
      ch       = ch_ff;
      ac       = ac_ff;
      ph       = ph_ff;
      n        = '0;
      is_zero  = (req_word.data == dcts_pkg::ZERO_BYTE);
      is_colon = (req_word.data == dcts_pkg::COLON_BYTE);
      pair     = 1'b0;
      for (int i = 0; i < OPS_MAX; i++) begin
         ops_in[i] = '0;
      end
      if (req_word.cmd == dcts_pkg::CMD_START) begin
         l  = '0;
         ch = 1'b0;
         ac = '0;
         if (req_word.message_length > PMAX_L) begin
            ops_in[n[1:0]] = mk_summary(dcts_pkg::STATUS_TOO_LONG, '0);
            n  = n + 3'd1;
            ph = PH_IGNORE;
         end else if (req_word.message_length == 16'd0) begin
            ops_in[n[1:0]] = mk_summary(dcts_pkg::STATUS_OK, '0);
            n  = n + 3'd1;
            ph = PH_IDLE;
         end else begin
            ph = PH_PARSE;
         end
      end else begin
         unique case (ph_ff)
            PH_PARSE: begin
               if (!is_zero && !is_colon) begin
                  if (ch) begin
                     if (l < TXB_L) begin
                        ops_in[n[1:0]] = mk_write(l, dcts_pkg::COLON_BYTE);
                        n = n + 3'd1;
                     end
                     if (l < TXB1_L) l = l + ONE_L;
                  end
                  ch = 1'b0;
                  if (l < TXB_L) begin
                     ops_in[n[1:0]] = mk_write(l, req_word.data);
                     n = n + 3'd1;
                  end
                  if (l < TXB1_L) l = l + ONE_L;
               end else if (is_colon) begin
                  pair = ch;
                  ch   = !ch;
               end
               if (is_zero || pair || req_word.end_of_message) begin
                  // a colon still held at the close belongs to the token
                  if (ch) begin
                     if (l < TXB_L) begin
                        ops_in[n[1:0]] = mk_write(l, dcts_pkg::COLON_BYTE);
                        n = n + 3'd1;
                     end
                     if (l < TXB1_L) l = l + ONE_L;
                  end
                  ch = 1'b0;
                  if (l >= ONE_L && l <= TXB_L && ac < TXS_L) begin
                     ops_in[n[1:0]] = mk_token(l, ac, !req_word.end_of_message);
                     n  = n + 3'd1;
                     ac = ac + ONE_C;
                     if (ac >= TXS_L) ph = PH_DONE;
                  end
                  l = '0;
               end
               if (is_zero) ph = PH_DONE;
               if (req_word.end_of_message) begin
                  ops_in[n[1:0]] = mk_summary(dcts_pkg::STATUS_OK, ac);
                  n  = n + 3'd1;
                  ph = PH_IDLE;
               end
            end
            PH_DONE: begin
               if (req_word.end_of_message) begin
                  ops_in[n[1:0]] = mk_summary(dcts_pkg::STATUS_OK, ac);
                  n  = n + 3'd1;
                  ph = PH_IDLE;
               end
            end
            PH_IGNORE: begin
               if (req_word.end_of_message) ph = PH_IDLE;
            end
            PH_IDLE: begin
               ph = PH_IDLE;
            end
            default: begin
               ph = PH_IDLE;
            end
         endcase
      end
      tl_in   = l;
      ch_in   = ch;
      ac_in   = ac;
      ph_in   = ph;
      nops_in = n;
      pos_in  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tl_ff   <= '0;
         ch_ff   <= 1'b0;
         ac_ff   <= '0;
         ph_ff   <= PH_IDLE;
         nops_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         tl_ff   <= tl_in;
         ch_ff   <= ch_in;
         ac_ff   <= ac_in;
         ph_ff   <= ph_in;
         nops_ff <= nops_in;
         pos_ff  <= pos_in;
      end else if (op_push) begin
         pos_ff  <= pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < OPS_MAX; i++) begin
            ops_ff[i] <= ops_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/dcts_queue.sv @@
`default_nettype none

module dcts_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire dcts_pkg::op_type  push_word,
   input  wire logic              pop,
   output logic                   empty,
   output dcts_pkg::op_type       pop_word
);

   dcts_pkg::op_type                    slot_ff [dcts_pkg::QUEUE_DEPTH];
   logic [dcts_pkg::QUEUE_PTR_W-1:0]    wp_ff, rp_ff;
   logic [dcts_pkg::QUEUE_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign full     = (cnt_ff == dcts_pkg::QUEUE_CNT_W'(dcts_pkg::QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = slot_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= push_word;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dcts_back.sv @@
`default_nettype none

module dcts_back #(
   parameter int unsigned TX_BYTES_MAX = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_empty,
   output logic                   op_pop,
   input  wire dcts_pkg::op_type  op_word,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output dcts_pkg::rsp_type      rsp_word
);

   localparam int unsigned LEN_W  = $clog2(TX_BYTES_MAX + 2);
   localparam int unsigned ADDR_W = (TX_BYTES_MAX > 1) ? $clog2(TX_BYTES_MAX) : 1;
   localparam logic [LEN_W-1:0] ONE_L = LEN_W'(1);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic [7:0] mem [TX_BYTES_MAX];
   logic [7:0] rdata_ff;

   logic             st_ff, st_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [dcts_pkg::INDEX_BITS-1:0] tix_ff, tix_in;
   logic             trl_ff, trl_in;

   logic             rdp_ff, rdp_in;
   logic             rlast_ff, rlast_in;
   logic             rrl_ff, rrl_in;
   logic [dcts_pkg::INDEX_BITS-1:0] rix_ff, rix_in;

   dcts_pkg::rsp_type ofifo_ff [2];
   logic [1:0]        ocnt_ff, ocnt_in;
   logic              owp_ff, orp_ff;
   logic              opush;
   dcts_pkg::rsp_type opush_word;
   logic              opop;
   logic              space;

   logic             mem_we;
   logic             mem_re;
   logic [ADDR_W-1:0] rd_addr;
   logic             is_last;

   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_word  = ofifo_ff[orp_ff];
   assign opop      = rsp_pop && !rsp_empty;
   assign space     = ((ocnt_ff + {1'b0, rdp_ff}) < 2'd2);
   assign rd_addr   = idx_ff[ADDR_W-1:0];
   assign is_last   = ((idx_ff + ONE_L) == len_ff);

   always_comb begin
      st_in      = st_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      tix_in     = tix_ff;
      trl_in     = trl_ff;
      rdp_in     = 1'b0;
      rlast_in   = rlast_ff;
      rrl_in     = rrl_ff;
      rix_in     = rix_ff;
      op_pop     = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      opush      = 1'b0;
      opush_word = '0;
      if (rdp_ff) begin
         opush               = 1'b1;
         opush_word.kind     = dcts_pkg::KIND_TX_BYTE;
         opush_word.out_byte = rdata_ff;
         opush_word.tx_index = rix_ff;
         opush_word.tx_last  = rlast_ff;
         opush_word.run_last = rrl_ff;
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (!op_empty) begin
               unique case (op_word.opcode)
                  dcts_pkg::OP_WRITE: begin
                     mem_we = 1'b1;
                     op_pop = 1'b1;
                  end
                  dcts_pkg::OP_TOKEN: begin
                     op_pop = 1'b1;
                     st_in  = ST_DRAIN;
                     idx_in = '0;
                     len_in = LEN_W'(op_word.length);
                     tix_in = op_word.index;
                     trl_in = op_word.run_last;
                  end
                  dcts_pkg::OP_SUMMARY: begin
                     if (!rdp_ff && space) begin
                        op_pop              = 1'b1;
                        opush               = 1'b1;
                        opush_word.kind     = dcts_pkg::KIND_SUMMARY;
                        opush_word.status   = op_word.status;
                        opush_word.tx_count = op_word.count;
                        opush_word.run_last = op_word.run_last;
                     end
                  end
                  default: begin
                     op_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (space) begin
               mem_re   = 1'b1;
               rdp_in   = 1'b1;
               rlast_in = is_last;
               rrl_in   = is_last && trl_ff;
               rix_in   = tix_ff;
               idx_in   = idx_ff + ONE_L;
               if (is_last) st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ocnt_in = ocnt_ff;
      if (opush && !opop) ocnt_in = ocnt_ff + 2'd1;
      if (opop && !opush) ocnt_in = ocnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[op_word.addr[ADDR_W-1:0]] <= op_word.value;
      if (mem_re) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         rdp_ff  <= 1'b0;
         ocnt_ff <= '0;
         owp_ff  <= 1'b0;
         orp_ff  <= 1'b0;
      end else begin
         st_ff   <= st_in;
         rdp_ff  <= rdp_in;
         ocnt_ff <= ocnt_in;
         if (opush) owp_ff <= !owp_ff;
         if (opop)  orp_ff <= !orp_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      tix_ff   <= tix_in;
      trl_ff   <= trl_in;
      rlast_ff <= rlast_in;
      rrl_ff   <= rrl_in;
      rix_ff   <= rix_in;
      if (opush) ofifo_ff[owp_ff] <= opush_word;
   end

endmodule

`default_nettype wire

@@ hw/rtl/double_colon_token_splitter.sv @@
// a start word's summary goes through the front op buffer, op queue and result buffer
// a popped token op's first byte passes the drain state, read register and result buffer
// the front takes a new word only once all ops of the last (up to 4) are in the op queue
// a closed token drains byte by byte, each read only while the result buffer has room
// reset: synchronous, active high; clears all control, queues and parse state
// the token buffer is not cleared; bytes of earlier tokens stay in it until overwritten
`default_nettype none

module double_colon_token_splitter #(
   parameter int unsigned TX_BYTES_MAX = 32,
   parameter int unsigned TXS_MAX      = 16,
   parameter int unsigned PAYLOAD_MAX  = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire dcts_pkg::req_type req_word,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output dcts_pkg::rsp_type      rsp_word
);

   logic             fq_push, fq_full, fq_pop, fq_empty;
   dcts_pkg::op_type fq_in_word, fq_out_word;

   dcts_front #(
      .TX_BYTES_MAX (TX_BYTES_MAX),
      .TXS_MAX      (TXS_MAX),
      .PAYLOAD_MAX  (PAYLOAD_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .op_push  (fq_push),
      .op_full  (fq_full),
      .op_word  (fq_in_word)
   );

   dcts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .full      (fq_full),
      .push_word (fq_in_word),
      .pop       (fq_pop),
      .empty     (fq_empty),
      .pop_word  (fq_out_word)
   );

   dcts_back #(
      .TX_BYTES_MAX (TX_BYTES_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (fq_empty),
      .op_pop    (fq_pop),
      .op_word   (fq_out_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

@@ tb/double_colon_token_splitter_checker.sv @@
`timescale 1ns / 1ps

module double_colon_token_splitter_checker #(
   parameter int unsigned TX_BYTES_MAX = 32,
   parameter int unsigned TXS_MAX      = 16,
   parameter int unsigned PAYLOAD_MAX  = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire logic              req_full,
   input  wire dcts_pkg::req_type req_word,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire dcts_pkg::rsp_type rsp_word,
   output int                     mismatch_count,
   output int                     outstanding
);

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_ACTIVE,
      PARSE_DONE,
      PARSE_IGNORE
   } parse_state_type;

   logic [7:0]        token_bytes [TX_BYTES_MAX];
   int unsigned       token_len;
   logic              colon_pending;
   int unsigned       tx_accepted;
   parse_state_type   parse_state;
   dcts_pkg::rsp_type expected_words [$];
   dcts_pkg::rsp_type step_words [$];
   int                errors = 0;

   task automatic add_result(input logic kind, input logic [7:0] value,
                             input int unsigned index, input logic last,
                             input logic status, input int unsigned count);
      dcts_pkg::rsp_type r;
      r.kind     = kind;
      r.out_byte = value;
      r.tx_index = index[dcts_pkg::INDEX_BITS-1:0];
      r.tx_last  = last;
      r.status   = status;
      r.tx_count = count[dcts_pkg::COUNT_BITS-1:0];
      r.run_last = 1'b0;
      step_words.push_back(r);
   endtask

   task automatic append_token_byte(input logic [7:0] value);
      if (token_len < TX_BYTES_MAX) token_bytes[token_len] = value;
      if (token_len < TX_BYTES_MAX + 1) token_len++;
   endtask

   task automatic close_token(input bit take_colon);
      if (take_colon && colon_pending) append_token_byte(dcts_pkg::COLON_BYTE);
      colon_pending = 1'b0;
      if (token_len >= 1 && token_len <= TX_BYTES_MAX && tx_accepted < TXS_MAX) begin
         for (int unsigned i = 0; i < token_len; i++) begin
            add_result(dcts_pkg::KIND_TX_BYTE, token_bytes[i], tx_accepted,
                       (i + 1 == token_len), dcts_pkg::STATUS_OK, 0);
         end
         tx_accepted++;
         if (tx_accepted >= TXS_MAX) parse_state = PARSE_DONE;
      end
      token_len = 0;
   endtask

   task automatic predict_word(input dcts_pkg::req_type w);
      dcts_pkg::rsp_type last_word;
      step_words.delete();
      if (w.cmd == dcts_pkg::CMD_START) begin
         token_len     = 0;
         colon_pending = 1'b0;
         tx_accepted   = 0;
         if (w.message_length > PAYLOAD_MAX) begin
            add_result(dcts_pkg::KIND_SUMMARY, 8'h00, 0, 1'b0, dcts_pkg::STATUS_TOO_LONG, 0);
            parse_state = PARSE_IGNORE;
         end else if (w.message_length == 0) begin
            add_result(dcts_pkg::KIND_SUMMARY, 8'h00, 0, 1'b0, dcts_pkg::STATUS_OK, 0);
            parse_state = PARSE_IDLE;
         end else begin
            parse_state = PARSE_ACTIVE;
         end
      end else if (parse_state == PARSE_ACTIVE) begin
         if (w.data == dcts_pkg::ZERO_BYTE) begin
            close_token(1'b1);
            parse_state = PARSE_DONE;
         end else if (w.data == dcts_pkg::COLON_BYTE) begin
            if (colon_pending) begin
               colon_pending = 1'b0;
               close_token(1'b0);
            end else begin
               colon_pending = 1'b1;
            end
         end else begin
            if (colon_pending) begin
               append_token_byte(dcts_pkg::COLON_BYTE);
               colon_pending = 1'b0;
            end
            append_token_byte(w.data);
         end
         if (w.end_of_message) begin
            if (parse_state == PARSE_ACTIVE) close_token(1'b1);
            add_result(dcts_pkg::KIND_SUMMARY, 8'h00, 0, 1'b0, dcts_pkg::STATUS_OK,
                       tx_accepted);
            parse_state = PARSE_IDLE;
         end
      end else if (parse_state == PARSE_DONE) begin
         if (w.end_of_message) begin
            add_result(dcts_pkg::KIND_SUMMARY, 8'h00, 0, 1'b0, dcts_pkg::STATUS_OK,
                       tx_accepted);
            parse_state = PARSE_IDLE;
         end
      end else if (parse_state == PARSE_IGNORE) begin
         if (w.end_of_message) parse_state = PARSE_IDLE;
      end
      if (step_words.size() > 0) begin
         last_word = step_words.pop_back();
         last_word.run_last = 1'b1;
         step_words.push_back(last_word);
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      dcts_pkg::rsp_type want;
      if (reset) begin
         token_len     = 0;
         colon_pending = 1'b0;
         tx_accepted   = 0;
         parse_state   = PARSE_IDLE;
         expected_words.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $error("result word with no expectation waiting");
               errors++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", want.kind, rsp_word.kind);
               check_field("out_byte", want.out_byte, rsp_word.out_byte);
               check_field("tx_index", want.tx_index, rsp_word.tx_index);
               check_field("tx_last", want.tx_last, rsp_word.tx_last);
               check_field("status", want.status, rsp_word.status);
               check_field("tx_count", want.tx_count, rsp_word.tx_count);
               check_field("run_last", want.run_last, rsp_word.run_last);
            end
         end
         if (req_push && !req_full) predict_word(req_word);
      end
      mismatch_count <= errors;
      outstanding    <= expected_words.size();
   end

endmodule

@@ tb/double_colon_token_splitter_tb.sv @@
`timescale 1ns / 1ps

module double_colon_token_splitter_tb;

   localparam int unsigned TX_BYTES_MAX = 32;
   localparam int unsigned TXS_MAX      = 16;
   localparam int unsigned PAYLOAD_MAX  = 4096;
   localparam int unsigned RANDOM_WORDS = 75;
   localparam int unsigned CALM_WORDS   = 50;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   dcts_pkg::req_type req_word = '0;
   logic              rsp_empty;
   logic              rsp_pop  = 1'b0;
   dcts_pkg::rsp_type rsp_word;
   int                mismatch_count;
   int                outstanding;
   bit                idling   = 1'b1;
   int unsigned       quiet_cycles = 0;
   logic [7:0]        payload [$];

   double_colon_token_splitter #(
      .TX_BYTES_MAX(TX_BYTES_MAX),
      .TXS_MAX     (TXS_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_word (req_word),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_word (rsp_word)
   );

   double_colon_token_splitter_checker #(
      .TX_BYTES_MAX(TX_BYTES_MAX),
      .TXS_MAX     (TXS_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) splitter_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_word      (req_word),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_word      (rsp_word),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] random_byte();
      return ($urandom_range(0, 3) == 0) ? dcts_pkg::COLON_BYTE : 8'($urandom_range(1, 255));
   endfunction

   task automatic send_word(input dcts_pkg::req_type w);
      @(negedge clock);
      if (idling && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_start(input int unsigned len);
      dcts_pkg::req_type w;
      w.cmd            = dcts_pkg::CMD_START;
      w.message_length = len[15:0];
      w.data           = 8'($urandom_range(0, 255));
      w.end_of_message = 1'($urandom_range(0, 1));
      send_word(w);
   endtask

   task automatic send_payload(input bit with_end);
      dcts_pkg::req_type w;
      foreach (payload[i]) begin
         w.cmd            = dcts_pkg::CMD_BYTE;
         w.message_length = 16'($urandom_range(0, 65535));
         w.data           = payload[i];
         w.end_of_message = with_end && (i == payload.size() - 1);
         send_word(w);
      end
   endtask

   // result side: random pop stalls until the calm tail
   initial begin
      forever begin
         @(negedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 15)) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("double_colon_token_splitter verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned sent_words;
      int unsigned msg_num;
      int unsigned pick;
      int unsigned tokens;
      int unsigned tok_size;
      sent_words = 0;
      msg_num    = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // byte while idle
      payload = {8'h41};
      send_payload(1'b1);
      // over-long messages, bytes ignored
      send_start(PAYLOAD_MAX + 1);
      payload = {dcts_pkg::COLON_BYTE, 8'h7e};
      send_payload(1'b1);
      send_start(16'hffff);
      payload = {8'h01};
      send_payload(1'b1);
      // empty message
      send_start(0);
      // greedy delimiter and held colon at the end
      send_start(PAYLOAD_MAX);
      payload = {8'h61, dcts_pkg::COLON_BYTE, dcts_pkg::COLON_BYTE, dcts_pkg::COLON_BYTE,
                 8'h62, dcts_pkg::COLON_BYTE};
      send_payload(1'b1);
      // zero byte closes with the held colon, later bytes ignored
      send_start(1);
      payload = {8'hff, dcts_pkg::COLON_BYTE, dcts_pkg::ZERO_BYTE, 8'h64};
      send_payload(1'b1);
      // start while busy, then zero as the final byte
      send_start(5);
      payload = {8'h66};
      send_payload(1'b0);
      send_start(3);
      payload = {8'h65, dcts_pkg::ZERO_BYTE};
      send_payload(1'b1);

      while (sent_words < RANDOM_WORDS) begin
         if (sent_words >= CALM_WORDS) idling = 1'b0;
         pick = (msg_num == 1) ? 3 : (msg_num == 3) ? 4 : $urandom_range(0, 15);
         msg_num++;
         payload.delete();
         case (pick)
            0: begin
               send_start($urandom_range(PAYLOAD_MAX + 1, 65535));
               repeat ($urandom_range(1, 3)) payload.push_back(random_byte());
               send_payload(1'b1);
               sent_words += payload.size() + 1;
            end
            1: begin
               send_start(0);
               sent_words++;
            end
            2: begin
               payload.push_back(random_byte());
               send_payload(1'($urandom_range(0, 1)));
               sent_words++;
            end
            default: begin
               // 3: count limit, 4: long token, 5: zero byte, 6: cut short
               tokens = (pick == 3) ? TXS_MAX + 1 : $urandom_range(1, 4);
               for (int unsigned t = 0; t < tokens; t++) begin
                  if (t != 0) begin
                     payload.push_back(dcts_pkg::COLON_BYTE);
                     payload.push_back(dcts_pkg::COLON_BYTE);
                  end
                  if (pick == 3) tok_size = 1;
                  else if (pick == 4 && t == 0)
                     tok_size = $urandom_range(TX_BYTES_MAX - 1, TX_BYTES_MAX + 2);
                  else tok_size = $urandom_range(0, 5);
                  repeat (tok_size) payload.push_back(random_byte());
               end
               if (payload.size() == 0) payload.push_back(random_byte());
               if (pick == 5)
                  payload.insert($urandom_range(0, payload.size() - 1), dcts_pkg::ZERO_BYTE);
               send_start(($urandom_range(0, 3) == 0) ? PAYLOAD_MAX :
                          $urandom_range(1, PAYLOAD_MAX));
               send_payload(pick != 6);
               sent_words += payload.size() + 1;
            end
         endcase
      end

      @(negedge clock);
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("double_colon_token_splitter verification clean");
      end else begin
         $display("double_colon_token_splitter verification failed");
      end
      $finish;
   end

endmodule
